FILE: src/oaht_pkg.sv
package oaht_pkg;
  localparam int TableSlots = 300;
  localparam int StepPrime  = 139;
  localparam int IdLimit    = 400;
  localparam int SlotW      = $clog2(TableSlots);
  localparam int IdW        = 9;
  localparam int PriceW     = 16;
  localparam int CntW       = $clog2(TableSlots + 1);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_NOFREE  = 3'd4;

  typedef struct packed {
    logic             used;
    logic [IdW-1:0]   key;
    logic             veg;
    logic [PriceW-1:0] price;
  } entry_t;
endpackage

FILE: src/oaht_ram.sv
module oaht_ram
  import oaht_pkg::*;
#(
  parameter int Depth = TableSlots,
  parameter int Width = $bits(entry_t)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: src/open_address_hash_table_core.sv
// Channel  Dir  Handshake              Words
// in       in   in_valid_i/in_ready_o  mode, food_id, probe_kind, veg, price
// out      out  out_valid_o/out_ready_i status, slot, found_veg, found_price
//
// One request at a time. A pass over all slots (one RAM read per cycle,
// registered read data) finds the lowest match and, for delete, clears
// each match; insert follows with a probe walk of up to TableSlots reads,
// since every read waits on the last one. Reset runs a clearing pass over
// all slots, in_ready_o low. A stalled result holds in the output reg.
module open_address_hash_table_core
  import oaht_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [IdW-1:0]    food_id_i,
  input  logic              probe_kind_i,
  input  logic              veg_i,
  input  logic [PriceW-1:0] price_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [8:0]        slot_o,
  output logic              found_veg_o,
  output logic [PriceW-1:0] found_price_o
);
  localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_SCAN = 3'd2,
                         S_PROBE = 3'd3, S_OUT = 3'd4;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(TableSlots - 1);

  logic [2:0]        state_q, state_d;
  logic [1:0]        mode_q;
  logic [IdW-1:0]    id_q;
  logic              kind_q, veg_q;
  logic [PriceW-1:0] price_q;
  logic [CntW-1:0]   fill_q, fill_d;
  // read address issued, address of data returning, probe step count
  logic [SlotW-1:0]  raddr_q, raddr_d, daddr_q, daddr_d;
  logic [SlotW-1:0]  step_q, step_d;
  logic [SlotW:0]    cnt_q, cnt_d;
  logic              rvalid_q, rvalid_d;
  logic              hit_q, hit_d;
  logic [SlotW-1:0]  hslot_q, hslot_d;
  logic              hveg_q, hveg_d;
  logic [PriceW-1:0] hprice_q, hprice_d;
  logic [2:0]        st_q, st_d;
  logic [8:0]        oslot_q, oslot_d;

  logic              we;
  logic [SlotW-1:0]  waddr, raddr;
  entry_t            wdata, rdata;

  oaht_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // ids stay below 2*TableSlots and 4*StepPrime, so compare and subtract
  // is enough for both remainders
  logic [SlotW-1:0] home, dstep;
  logic [IdW-1:0]   id_mod_step;
  logic [SlotW:0]   nxt_lin, nxt_dbl;
  always_comb begin
    home = (id_q >= IdW'(TableSlots)) ? SlotW'(id_q - IdW'(TableSlots)) : SlotW'(id_q);
    if (id_q >= IdW'(3 * StepPrime)) id_mod_step = id_q - IdW'(3 * StepPrime);
    else if (id_q >= IdW'(2 * StepPrime)) id_mod_step = id_q - IdW'(2 * StepPrime);
    else if (id_q >= IdW'(StepPrime)) id_mod_step = id_q - IdW'(StepPrime);
    else id_mod_step = id_q;
    dstep = SlotW'(StepPrime) - SlotW'(id_mod_step);
    nxt_lin = {1'b0, daddr_q} + 1'b1;
    nxt_dbl = {1'b0, daddr_q} + {1'b0, step_q};
  end

  logic match;
  assign match = rvalid_q && rdata.used && (rdata.key == id_q);

  always_comb begin
    state_d = state_q; fill_d = fill_q; raddr_d = raddr_q; daddr_d = daddr_q;
    step_d = step_q; cnt_d = cnt_q; rvalid_d = 1'b0; hit_d = hit_q;
    hslot_d = hslot_q; hveg_d = hveg_q; hprice_d = hprice_q;
    st_d = st_q; oslot_d = oslot_q;
    we = 1'b0; waddr = daddr_q; wdata = '0; raddr = raddr_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1; waddr = raddr_q;
        raddr_d = raddr_q + 1'b1;
        if (raddr_q == LastSlot) begin
          raddr_d = '0; state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_SCAN; raddr_d = '0; hit_d = 1'b0;
          cnt_d = '0;
        end
      end
      S_SCAN: begin
        if (cnt_q < (SlotW+1)'(TableSlots)) begin
          raddr = raddr_q; rvalid_d = 1'b1;
          daddr_d = raddr_q; raddr_d = raddr_q + 1'b1; cnt_d = cnt_q + 1'b1;
        end
        if (match) begin
          if (!hit_q) begin
            hit_d = 1'b1; hslot_d = daddr_q; hveg_d = rdata.veg;
            hprice_d = rdata.price;
          end
          if (mode_q == MODE_DELETE) begin
            we = 1'b1; waddr = daddr_q;
            if (fill_d != '0) fill_d = fill_d - 1'b1;
          end
        end
        if (cnt_q == (SlotW+1)'(TableSlots) && !rvalid_q) begin
          state_d = S_OUT; oslot_d = '0; st_d = ST_DONE;
          // found data goes out on lookup only
          hveg_d = (hit_d && mode_q != MODE_DELETE) ? hveg_d : 1'b0;
          hprice_d = (hit_d && mode_q != MODE_DELETE) ? hprice_d : '0;
          if (mode_q == MODE_INSERT) begin
            hveg_d = 1'b0; hprice_d = '0;
            if (hit_d) st_d = ST_DUP;
            else if (id_q >= IdW'(IdLimit)) st_d = ST_MISSING;
            else if (fill_q >= CntW'(TableSlots)) st_d = ST_FULL;
            else begin
              state_d = S_PROBE; raddr_d = home; cnt_d = '0;
              step_d = kind_q ? dstep : '0;
            end
          end else if (hit_d) oslot_d = 9'(hslot_d);
          else st_d = ST_MISSING;
        end
      end
      S_PROBE: begin
        // issue reads one at a time; each result decides the next address
        if (!rvalid_q) begin
          raddr = raddr_q; rvalid_d = 1'b1; daddr_d = raddr_q;
        end else if (!rdata.used) begin
          we = 1'b1; waddr = daddr_q;
          wdata = '{used: 1'b1, key: id_q, veg: veg_q, price: price_q};
          fill_d = fill_q + 1'b1; st_d = ST_DONE; oslot_d = 9'(daddr_q);
          state_d = S_OUT;
        end else if (cnt_q == (SlotW+1)'(TableSlots - 1)) begin
          st_d = ST_NOFREE; oslot_d = '0; state_d = S_OUT;
        end else begin
          cnt_d = cnt_q + 1'b1;
          if (!kind_q) raddr_d = (nxt_lin >= (SlotW+1)'(TableSlots)) ? '0
                                 : nxt_lin[SlotW-1:0];
          else raddr_d = (nxt_dbl >= (SlotW+1)'(TableSlots))
                         ? SlotW'(nxt_dbl - (SlotW+1)'(TableSlots))
                         : nxt_dbl[SlotW-1:0];
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o   = (state_q == S_OUT);
  assign status_o      = st_q;
  assign slot_o        = oslot_q;
  assign found_veg_o   = hveg_q;
  assign found_price_o = hprice_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; fill_q <= '0; raddr_q <= '0; rvalid_q <= 1'b0;
      cnt_q <= '0; hit_q <= 1'b0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; raddr_q <= raddr_d;
      rvalid_q <= rvalid_d; cnt_q <= cnt_d; hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    daddr_q <= daddr_d; step_q <= step_d; hslot_q <= hslot_d;
    hveg_q <= hveg_d; hprice_q <= hprice_d; st_q <= st_d; oslot_q <= oslot_d;
    if (in_ready_o && in_valid_i) begin
      mode_q <= mode_i; id_q <= food_id_i; kind_q <= probe_kind_i;
      veg_q <= veg_i; price_q <= price_i;
    end
  end
endmodule

FILE: sim/open_address_hash_table_core_tb.sv
module open_address_hash_table_core_tb
  import oaht_pkg::*;
();

  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;  // decodes as lookup
  localparam int StallLimit = 6000;
  localparam int HoldCycles = 500;

  typedef struct packed {
    logic [2:0]        status;
    logic [8:0]        slot;
    logic              veg;
    logic [PriceW-1:0] price;
  } answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        mode_i;
  logic [IdW-1:0]    food_id_i;
  logic              probe_kind_i;
  logic              veg_i;
  logic [PriceW-1:0] price_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [2:0]        status_o;
  logic [8:0]        slot_o;
  logic              found_veg_o;
  logic [PriceW-1:0] found_price_o;

  open_address_hash_table_core i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow table
  logic              tbl_used [TableSlots];
  logic [IdW-1:0]    tbl_key  [TableSlots];
  logic              tbl_veg  [TableSlots];
  logic [PriceW-1:0] tbl_price[TableSlots];
  int                tbl_fill;

  answer_t answer_q[$];
  int tx_idle_pct, rx_stall_pct;
  int n_words, n_answers, n_errors;
  int n_status[5];
  bit hold_req;

  function automatic int lowest_match(logic [IdW-1:0] id);
    for (int i = 0; i < TableSlots; i++)
      if (tbl_used[i] && tbl_key[i] == id) return i;
    return TableSlots;
  endfunction

  function automatic int free_on_path(logic [IdW-1:0] id, logic kind);
    int home, pos, stride;
    home = id % TableSlots;
    pos = home;
    stride = (StepPrime - id % StepPrime) % TableSlots;
    if (!tbl_used[home]) return home;
    for (int i = 1; i < TableSlots; i++) begin
      pos = kind ? (pos + stride) % TableSlots : (pos + 1) % TableSlots;
      if (!tbl_used[pos]) return pos;
    end
    return TableSlots;
  endfunction

  // applies one request to the shadow table and returns the answer
  function automatic answer_t serve(logic [1:0] mode, logic [IdW-1:0] id, logic kind,
                                    logic veg, logic [PriceW-1:0] price);
    answer_t a;
    int s;
    a = '0;
    s = lowest_match(id);
    if (mode == MODE_INSERT) begin
      if (s < TableSlots) a.status = ST_DUP;
      else if (id >= IdLimit) a.status = ST_MISSING;
      else if (tbl_fill >= TableSlots) a.status = ST_FULL;
      else begin
        s = free_on_path(id, kind);
        if (s >= TableSlots) a.status = ST_NOFREE;
        else begin
          tbl_used[s] = 1'b1; tbl_key[s] = id; tbl_veg[s] = veg; tbl_price[s] = price;
          tbl_fill++;
          a.status = ST_DONE; a.slot = 9'(s);
        end
      end
    end else if (mode == MODE_DELETE) begin
      if (s >= TableSlots) a.status = ST_MISSING;
      else begin
        a.slot = 9'(s);
        for (int i = s; i < TableSlots; i++)
          if (tbl_used[i] && tbl_key[i] == id) begin
            tbl_used[i] = 1'b0;
            if (tbl_fill > 0) tbl_fill--;
          end
      end
    end else begin
      if (s >= TableSlots) a.status = ST_MISSING;
      else begin
        a.slot = 9'(s); a.veg = tbl_veg[s]; a.price = tbl_price[s];
      end
    end
    return a;
  endfunction

  task automatic send_word(logic [1:0] mode, logic [IdW-1:0] id, logic kind,
                           logic veg, logic [PriceW-1:0] price);
    int gap;
    in_valid_i <= 1'b1;
    mode_i <= mode; food_id_i <= id; probe_kind_i <= kind; veg_i <= veg; price_i <= price;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    answer_q.push_back(serve(mode, id, kind, veg, price));
    n_words++;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic rand_word(int id_max, int ins_pct, int del_pct);
    int r;
    logic [1:0] mode;
    r = $urandom_range(99);
    if (r < ins_pct) mode = MODE_INSERT;
    else if (r < ins_pct + del_pct) mode = MODE_DELETE;
    else mode = ($urandom_range(7) == 0) ? MODE_SPARE : MODE_LOOKUP;
    send_word(mode, IdW'($urandom_range(id_max)), 1'($urandom_range(1)),
              1'($urandom_range(1)), PriceW'($urandom_range(16'hffff)));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    tx_idle_pct = 0; rx_stall_pct = 0;
    send_word(MODE_INSERT, 9'd0,   1'b0, 1'b1, 16'hffff);
    send_word(MODE_INSERT, 9'd300, 1'b0, 1'b0, 16'h0000); // home taken, linear
    send_word(MODE_INSERT, 9'd1,   1'b1, 1'b0, 16'h5a5a);
    send_word(MODE_INSERT, 9'd301, 1'b1, 1'b1, 16'ha5a5); // home taken, double hash
    send_word(MODE_INSERT, 9'd299, 1'b1, 1'b1, 16'h1234); // top slot
    send_word(MODE_INSERT, 9'd399, 1'b0, 1'b0, 16'h8001); // home slot 99, free
    send_word(MODE_INSERT, 9'd0,   1'b1, 1'b0, 16'h0001); // duplicate
    send_word(MODE_INSERT, 9'd400, 1'b0, 1'b1, 16'h00ff); // out of range
    send_word(MODE_INSERT, 9'd511, 1'b1, 1'b1, 16'hff00);
    send_word(MODE_LOOKUP, 9'd0,   1'b0, 1'b0, 16'h0);
    send_word(MODE_LOOKUP, 9'd301, 1'b1, 1'b1, 16'hffff);
    send_word(MODE_SPARE,  9'd399, 1'b0, 1'b0, 16'h0);
    send_word(MODE_LOOKUP, 9'd511, 1'b0, 1'b0, 16'h0);
    send_word(MODE_DELETE, 9'd77,  1'b0, 1'b0, 16'h0);    // missing
    send_word(MODE_DELETE, 9'd0,   1'b0, 1'b0, 16'h0);
    send_word(MODE_LOOKUP, 9'd300, 1'b0, 1'b0, 16'h0);
    send_word(MODE_DELETE, 9'd300, 1'b0, 1'b0, 16'h0);
    send_word(MODE_DELETE, 9'd300, 1'b0, 1'b0, 16'h0);    // already gone
    send_word(MODE_LOOKUP, 9'd0,   1'b0, 1'b0, 16'h0);
    drain();
  endtask

  // fill to capacity with mostly double hashing: exercises no-free-slot and full
  task automatic test_fill();
    int ids[$];
    for (int i = 0; i < IdLimit; i++) ids.push_back(i);
    ids.shuffle();
    tx_idle_pct = 49; rx_stall_pct = 0;
    for (int i = 0; i < 340; i++) begin
      if (i == 120) begin tx_idle_pct = 0; rx_stall_pct = 49; end
      if (i == 240) begin tx_idle_pct = 10; rx_stall_pct = 10; end
      if ($urandom_range(9) == 0) rand_word(511, 0, 0);
      else send_word(MODE_INSERT, IdW'(ids[i % IdLimit]), $urandom_range(3) != 0,
                     1'($urandom_range(1)), PriceW'($urandom_range(16'hffff)));
    end
    drain();
  endtask

  task automatic test_churn();
    tx_idle_pct = 10; rx_stall_pct = 10;
    for (int i = 0; i < 140; i++) begin
      if (i == 70) begin tx_idle_pct = 0; rx_stall_pct = 0; end
      rand_word((i % 10 == 0) ? 511 : IdLimit - 1, 35, 35);
    end
    drain();
  endtask

  // receiver holds off while words keep coming; the block must back up
  task automatic test_backpressure();
    tx_idle_pct = 0; rx_stall_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) rand_word(IdLimit - 1, 40, 30);
    drain();
  endtask

  task automatic test_empty_out();
    tx_idle_pct = 49; rx_stall_pct = 49;
    for (int i = 0; i < IdLimit; i += 3) send_word(MODE_DELETE, IdW'(i), 1'b0, 1'b0, 16'h0);
    drain();
  endtask

  // receiver
  int hold_cnt;
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result check
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_o, slot_o, found_veg_o, found_price_o};
      n_answers++;
      if (answer_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected answer %p", got);
      end else begin
        want = answer_q.pop_front();
        if (want.status <= ST_NOFREE) n_status[want.status]++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"mismatch: exp st=%0d slot=%0d veg=%0b price=%h",
                      " got st=%0d slot=%0d veg=%0b price=%h"},
                     want.status, want.slot, want.veg, want.price,
                     got.status, got.slot, got.veg, got.price);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; mode_i = MODE_INSERT; food_id_i = '0; probe_kind_i = 1'b0;
    veg_i = 1'b0; price_i = '0; out_ready_i = 1'b0;
    hold_req = 1'b0; hold_cnt = 0;
    tx_idle_pct = 0; rx_stall_pct = 0;
    for (int i = 0; i < TableSlots; i++) begin
      tbl_used[i] = 1'b0; tbl_key[i] = '0; tbl_veg[i] = 1'b0; tbl_price[i] = '0;
    end
    tbl_fill = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill();
    test_churn();
    test_backpressure();
    test_empty_out();
    repeat (20) @(posedge clk_i);
    $display("%0d words, %0d answers; done=%0d full=%0d dup=%0d missing=%0d nofree=%0d",
             n_words, n_answers, n_status[0], n_status[1], n_status[2], n_status[3],
             n_status[4]);
    $display("covered insert/delete/lookup, linear and double probing, fill to capacity");
    if (n_errors == 0 && answer_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/oaht_pkg.sv
src/oaht_ram.sv
src/open_address_hash_table_core.sv
sim/open_address_hash_table_core_tb.sv
